### rtl/msp_pkg.sv
// Shared types, constants and register codes of the motor feedback speed loop.
// Depends on nothing; msp_front, msp_queue, msp_back, the top level and the testbench import it.
package msp_pkg;

  // Sizing
  localparam int CHANNELS   = 2;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // Encoder counts per turn, a power of two
  localparam int ENC_COUNTS = 8192;
  localparam int ANGLE_W    = $clog2(ENC_COUNTS);
  localparam int DELTA_W    = ANGLE_W + 1;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = QPTR_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN    = 3'd0,
    CFG_INTEG_GAIN   = 3'd1,
    CFG_DERIV_GAIN   = 3'd2,
    CFG_FILTER_GAIN  = 3'd3,
    CFG_OUTPUT_LIMIT = 3'd4,
    CFG_DECIMATION   = 3'd5,
    CFG_CHAN0_ID     = 3'd6,
    CFG_CHAN1_ID     = 3'd7
  } cfg_idx_e;

  // Register reset values
  localparam logic [8:0]  FILTER_GAIN_RST  = 9'd102;
  localparam logic [14:0] OUTPUT_LIMIT_RST = 15'd5000;
  localparam logic [2:0]  DECIMATION_RST   = 3'd5;
  localparam logic [10:0] CHAN0_ID_RST     = 11'h201;
  localparam logic [10:0] CHAN1_ID_RST     = 11'h203;
  // Unity weight of the filter in Q1.8
  localparam logic [8:0]  FILTER_ONE       = 9'd256;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] deriv_gain;
    logic [8:0]  filter_gain;
    logic [14:0] output_limit;
    logic [2:0]  decimation;
    logic [10:0] chan0_id;
    logic [10:0] chan1_id;
  } cfg_t;

  // Classified frame passed from front to back
  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [ANGLE_W-1:0] angle;
    logic [15:0]        current_real;
    logic [15:0]        current_set;
    logic [7:0]         hall;
    logic [15:0]        target_speed;
    logic               startup_hold;
  } item_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

### rtl/msp_in_if.sv
// Feedback frame channel: valid/ready handshake plus the received frame fields.
// Depends on nothing.
interface msp_in_if;
  logic               valid;
  logic               ready;
  logic [10:0]        std_id;
  logic [7:0]         angle_high;
  logic [7:0]         angle_low;
  logic [7:0]         current_high;
  logic [7:0]         current_low;
  logic [7:0]         setcur_high;
  logic [7:0]         setcur_low;
  logic [7:0]         hall_byte;
  logic signed [15:0] target_speed;
  logic               startup_hold;

  modport source (
    output valid, std_id, angle_high, angle_low, current_high, current_low,
           setcur_high, setcur_low, hall_byte, target_speed, startup_hold,
    input  ready
  );
  modport sink (
    input  valid, std_id, angle_high, angle_low, current_high, current_low,
           setcur_high, setcur_low, hall_byte, target_speed, startup_hold,
    output ready
  );
endinterface

### rtl/msp_out_if.sv
// Result channel: valid/ready handshake plus the per-frame channel status fields.
// Depends on nothing.
interface msp_out_if;
  logic               valid;
  logic               ready;
  logic               channel;
  logic [12:0]        angle;
  logic signed [13:0] speed_delta;
  logic signed [15:0] turns;
  logic signed [31:0] position;
  logic signed [15:0] current_real;
  logic signed [15:0] current_set;
  logic [7:0]         hall;
  logic               loop_ran;
  logic signed [15:0] filtered_speed;
  logic signed [15:0] drive;

  modport source (
    output valid, channel, angle, speed_delta, turns, position, current_real,
           current_set, hall, loop_ran, filtered_speed, drive,
    input  ready
  );
  modport sink (
    input  valid, channel, angle, speed_delta, turns, position, current_real,
           current_set, hall, loop_ran, filtered_speed, drive,
    output ready
  );
endinterface

### rtl/msp_front.sv
// Front end: takes feedback frames, matches the id to a channel, decodes bytes.
// Depends on msp_pkg and msp_in_if; feeds msp_queue.
module msp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  msp_pkg::cfg_t cfg_i,
  msp_in_if.sink        in_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output msp_pkg::item_t push_item_o
);
  import msp_pkg::*;

  logic        stg_valid_q, stg_valid_d;
  item_t       stg_item_q;
  item_t       dec_item;
  logic        match;
  logic        accept;
  logic [15:0] raw_angle;

  // Id match: channel 0 wins when both ids are equal
  always_comb begin
    raw_angle            = {in_i.angle_high, in_i.angle_low};
    dec_item.angle       = raw_angle[ANGLE_W-1:0];
    dec_item.current_real = {in_i.current_high, in_i.current_low};
    dec_item.current_set  = {in_i.setcur_high, in_i.setcur_low};
    dec_item.hall         = in_i.hall_byte;
    dec_item.target_speed = in_i.target_speed;
    dec_item.startup_hold = in_i.startup_hold;
    match                 = 1'b0;
    dec_item.ch           = '0;
    priority if (in_i.std_id == cfg_i.chan0_id) begin
      match = 1'b1;
    end else if ((in_i.std_id == cfg_i.chan1_id) && (CHANNELS > 1)) begin
      match       = 1'b1;
      dec_item.ch = CH_W'(1);
    end else begin
      match = 1'b0;
    end
  end

  assign in_i.ready = !stg_valid_q || push_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  // Stage register; unmatched frames are dropped here
  always_comb begin
    stg_valid_d = stg_valid_q;
    if (accept) begin
      stg_valid_d = match;
    end else if (push_ready_i) begin
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_item_q <= dec_item;
    end
  end

  assign push_valid_o = stg_valid_q;
  assign push_item_o  = stg_item_q;

endmodule

### rtl/msp_queue.sv
// Short queue of classified frames between front end and back end.
// Depends on msp_pkg.
module msp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  msp_pkg::item_t   push_item_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output msp_pkg::item_t   pop_item_o,
  output msp_pkg::q_stat_t stat_o
);
  import msp_pkg::*;

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign stat_o.count = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= QPTR_W'(wr_ptr_q + QPTR_W'(1));
      end
      if (do_pop) begin
        rd_ptr_q <= QPTR_W'(rd_ptr_q + QPTR_W'(1));
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### rtl/msp_back.sv
// Back end: per-channel unwrap, turn/position tracking, decimated filter and PID
// on one shared multiplier, and the result register. Depends on msp_pkg, msp_out_if.
module msp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  msp_pkg::cfg_t  cfg_i,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  msp_pkg::item_t pop_item_i,
  msp_out_if.source      out_o
);
  import msp_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b00000000001,
    ST_UNWRAP   = 11'b00000000010,
    ST_MUL_SUM  = 11'b00000000100,
    ST_MUL_FILT = 11'b00000001000,
    ST_FILT     = 11'b00000010000,
    ST_MUL_E    = 11'b00000100000,
    ST_MUL_E1   = 11'b00001000000,
    ST_MUL_E2   = 11'b00010000000,
    ST_OUT      = 11'b00100000000,
    ST_CLAMP    = 11'b01000000000,
    ST_EMIT     = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // Per-channel state
  logic [ANGLE_W-1:0] last_angle_q [CHANNELS];
  logic [15:0]        turns_q      [CHANNELS];
  logic [31:0]        pos_q        [CHANNELS];
  logic [15:0]        sum_q        [CHANNELS];
  logic [2:0]         decim_q      [CHANNELS];
  logic [15:0]        filt_q       [CHANNELS];
  logic [16:0]        ep1_q        [CHANNELS];
  logic [16:0]        ep2_q        [CHANNELS];
  logic [31:0]        outp_q       [CHANNELS];
  logic [15:0]        drive_q      [CHANNELS];

  // Working registers of the item in flight
  item_t              item_q;
  logic [DELTA_W-1:0] spd_q;
  logic               run_q;
  logic signed [37:0] acc_q, acc_d;
  logic signed [16:0] e_q;
  logic [17:0]        ksum_q, k1_q;
  logic [31:0]        o_q;

  // Result register
  logic               out_valid_q;
  logic               res_ch_q;
  logic [12:0]        res_angle_q;
  logic [13:0]        res_spd_q;
  logic [15:0]        res_turns_q;
  logic [31:0]        res_pos_q;
  logic [15:0]        res_cur_q, res_set_q, res_filt_q, res_drive_q;
  logic [7:0]         res_hall_q;
  logic               res_run_q;

  logic [CH_W-1:0]    ch;
  logic               do_pop, do_emit;

  // Unwrap datapath
  logic signed [DELTA_W-1:0] d;
  logic signed [DELTA_W-1:0] spd;
  logic                      dec_turn, inc_turn;
  logic signed [16:0]        sum17;
  logic [15:0]               sum_sat;
  logic [3:0]                cnt4;
  logic [2:0]                cnt_new;

  // Filter and PID datapath
  logic [8:0]          a_eff;
  logic [8:0]          a_inv;
  logic signed [18:0]  mul_a;
  logic signed [16:0]  mul_b;
  logic signed [35:0]  prod;
  logic signed [37:0]  prod_x;
  logic signed [37:0]  acc_rnd;
  logic [15:0]         filt_new;
  logic signed [29:0]  q30;
  logic signed [33:0]  sum34;
  logic [31:0]         o_sat;
  logic signed [31:0]  lim32, o_s;
  logic [31:0]         drive32;

  assign ch          = item_q.ch;
  assign pop_ready_o = (state_q == ST_IDLE);
  assign do_pop      = pop_valid_i && pop_ready_o;
  assign do_emit     = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  // Angle unwrap across the encoder wrap
  always_comb begin
    d        = $signed({1'b0, item_q.angle}) - $signed({1'b0, last_angle_q[ch]});
    dec_turn = (d > $signed(DELTA_W'(ENC_COUNTS / 2)));
    inc_turn = (d < -$signed(DELTA_W'(ENC_COUNTS / 2)));
    priority if (dec_turn) begin
      spd = d - $signed(DELTA_W'(ENC_COUNTS));
    end else if (inc_turn) begin
      spd = d + $signed(DELTA_W'(ENC_COUNTS));
    end else begin
      spd = d;
    end
    sum17 = $signed({sum_q[ch][15], sum_q[ch]}) + 17'(spd);
    priority if (sum17 > 17'sd32767) begin
      sum_sat = 16'h7FFF;
    end else if (sum17 < -17'sd32768) begin
      sum_sat = 16'h8000;
    end else begin
      sum_sat = sum17[15:0];
    end
    cnt4    = {1'b0, decim_q[ch]} + 4'd1;
    cnt_new = (cnt4 >= {1'b0, cfg_i.decimation}) ? 3'd0 : cnt4[2:0];
  end

  // Shared multiplier and accumulator
  always_comb begin
    a_eff = (cfg_i.filter_gain > FILTER_ONE) ? FILTER_ONE : cfg_i.filter_gain;
    a_inv = FILTER_ONE - a_eff;
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MUL_SUM: begin
        mul_a = $signed({10'b0, a_eff});
        mul_b = $signed({sum_q[ch][15], sum_q[ch]});
      end
      ST_MUL_FILT: begin
        mul_a = $signed({10'b0, a_inv});
        mul_b = $signed({filt_q[ch][15], filt_q[ch]});
      end
      ST_MUL_E: begin
        mul_a = $signed({1'b0, ksum_q});
        mul_b = e_q;
      end
      ST_MUL_E1: begin
        mul_a = $signed({1'b0, k1_q});
        mul_b = $signed(ep1_q[ch]);
      end
      ST_MUL_E2: begin
        mul_a = $signed({3'b0, cfg_i.deriv_gain});
        mul_b = $signed(ep2_q[ch]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod   = mul_a * mul_b;
    prod_x = {{2{prod[35]}}, prod};
    acc_d  = acc_q;
    unique case (state_q)
      ST_MUL_SUM:                       acc_d = prod_x;
      ST_MUL_FILT, ST_MUL_E, ST_MUL_E2: acc_d = acc_q + prod_x;
      ST_MUL_E1:                        acc_d = acc_q - prod_x;
      ST_FILT:                          acc_d = '0;
      default:                          acc_d = acc_q;
    endcase
  end

  // Division by 256 rounded toward zero, output saturation and drive clamp
  always_comb begin
    acc_rnd  = acc_q + (acc_q[37] ? 38'sd255 : 38'sd0);
    filt_new = item_q.startup_hold ? 16'd0 : acc_rnd[23:8];
    q30      = acc_rnd[37:8];
    sum34    = $signed({{2{outp_q[ch][31]}}, outp_q[ch]}) + $signed({{4{q30[29]}}, q30});
    if (sum34[33:31] != {3{sum34[33]}}) begin
      o_sat = sum34[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      o_sat = sum34[31:0];
    end
    lim32 = $signed({17'b0, cfg_i.output_limit});
    o_s   = $signed(o_q);
    priority if (o_s > lim32) begin
      drive32 = lim32;
    end else if (o_s < -lim32) begin
      drive32 = -lim32;
    end else begin
      drive32 = o_q;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (do_pop) state_d = ST_UNWRAP;
      ST_UNWRAP:   state_d = (cnt_new == 3'd0) ? ST_MUL_SUM : ST_EMIT;
      ST_MUL_SUM:  state_d = ST_MUL_FILT;
      ST_MUL_FILT: state_d = ST_FILT;
      ST_FILT:     state_d = ST_MUL_E;
      ST_MUL_E:    state_d = ST_MUL_E1;
      ST_MUL_E1:   state_d = ST_MUL_E2;
      ST_MUL_E2:   state_d = ST_OUT;
      ST_OUT:      state_d = ST_CLAMP;
      ST_CLAMP:    state_d = ST_EMIT;
      ST_EMIT:     if (do_emit) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control and per-channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        last_angle_q[c] <= '0;
        turns_q[c]      <= '0;
        pos_q[c]        <= '0;
        sum_q[c]        <= '0;
        decim_q[c]      <= 3'd1;
        filt_q[c]       <= '0;
        ep1_q[c]        <= '0;
        ep2_q[c]        <= '0;
        outp_q[c]       <= '0;
        drive_q[c]      <= '0;
      end
    end else begin
      state_q <= state_d;
      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_UNWRAP: begin
          last_angle_q[ch] <= item_q.angle;
          pos_q[ch]        <= pos_q[ch] + 32'(spd);
          sum_q[ch]        <= sum_sat;
          decim_q[ch]      <= cnt_new;
          if (dec_turn) begin
            turns_q[ch] <= turns_q[ch] - 16'd1;
          end else if (inc_turn) begin
            turns_q[ch] <= turns_q[ch] + 16'd1;
          end
        end
        ST_FILT: begin
          filt_q[ch] <= filt_new;
        end
        ST_OUT: begin
          ep2_q[ch]  <= ep1_q[ch];
          ep1_q[ch]  <= e_q;
          outp_q[ch] <= o_sat;
          sum_q[ch]  <= '0;
        end
        ST_CLAMP: begin
          drive_q[ch] <= drive32[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (do_pop) begin
      item_q <= pop_item_i;
    end
    if (state_q == ST_UNWRAP) begin
      spd_q <= spd;
      run_q <= (cnt_new == 3'd0);
    end
    if (state_q == ST_FILT) begin
      e_q    <= $signed({item_q.target_speed[15], item_q.target_speed})
              - $signed({filt_new[15], filt_new});
      ksum_q <= {2'b0, cfg_i.prop_gain} + {2'b0, cfg_i.integ_gain}
              + {2'b0, cfg_i.deriv_gain};
      k1_q   <= {2'b0, cfg_i.prop_gain} + {1'b0, cfg_i.deriv_gain, 1'b0};
    end
    if (state_q == ST_OUT) begin
      o_q <= o_sat;
    end
    if (do_emit) begin
      res_ch_q    <= 1'(ch);
      res_angle_q <= 13'(item_q.angle);
      res_spd_q   <= 14'(spd_q);
      res_turns_q <= turns_q[ch];
      res_pos_q   <= pos_q[ch];
      res_cur_q   <= item_q.current_real;
      res_set_q   <= item_q.current_set;
      res_hall_q  <= item_q.hall;
      res_run_q   <= run_q;
      res_filt_q  <= filt_q[ch];
      res_drive_q <= drive_q[ch];
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.channel        = res_ch_q;
  assign out_o.angle          = res_angle_q;
  assign out_o.speed_delta    = res_spd_q;
  assign out_o.turns          = res_turns_q;
  assign out_o.position       = res_pos_q;
  assign out_o.current_real   = res_cur_q;
  assign out_o.current_set    = res_set_q;
  assign out_o.hall           = res_hall_q;
  assign out_o.loop_ran       = res_run_q;
  assign out_o.filtered_speed = res_filt_q;
  assign out_o.drive          = res_drive_q;

endmodule

### rtl/motor_feedback_speed_pid.sv
// Motor feedback speed loop, two channels: top level with the register file.
// Depends on msp_pkg, msp_in_if, msp_out_if, msp_front, msp_queue, msp_back.
//
// in_i carries one received feedback frame per item. Frames whose std_id
// matches neither channel id are consumed and produce no result; channel 0
// wins when both ids are equal. Each matched frame yields exactly one item
// on out_o, in order.
// A frame passes the front stage register and the queue, then the back end
// sequencer: unwrap and emit for a frame without a control update, and the
// filter and PID steps as well when the decimation counter fires. The back end
// handles one frame at a time; its sequencer runs the filter and the three PID
// products one after another through a single 19x17 multiplier.
// The front stage and a two-entry queue keep taking frames while the back
// end works or its result waits; when out_o.ready stays low the result
// register holds, the queue fills and in_i.ready drops.
// Configuration is a write-only port (cfg_we_i, cfg_idx_i, cfg_data_i),
// written while the block is idle. Reset (rst_ni low, asynchronous) restores
// register defaults, clears all channel state and empties the pipeline.
module motor_feedback_speed_pid (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [msp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [msp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  msp_in_if.sink                           in_i,
  msp_out_if.source                        out_o
);
  import msp_pkg::*;

  cfg_t    cfg_q;
  logic    push_valid, push_ready;
  item_t   push_item;
  logic    pop_valid, pop_ready;
  item_t   pop_item;
  q_stat_t q_stat;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain    <= '0;
      cfg_q.integ_gain   <= '0;
      cfg_q.deriv_gain   <= '0;
      cfg_q.filter_gain  <= FILTER_GAIN_RST;
      cfg_q.output_limit <= OUTPUT_LIMIT_RST;
      cfg_q.decimation   <= DECIMATION_RST;
      cfg_q.chan0_id     <= CHAN0_ID_RST;
      cfg_q.chan1_id     <= CHAN1_ID_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_data_i[15:0];
        CFG_INTEG_GAIN:   cfg_q.integ_gain   <= cfg_data_i[15:0];
        CFG_DERIV_GAIN:   cfg_q.deriv_gain   <= cfg_data_i[15:0];
        CFG_FILTER_GAIN:  cfg_q.filter_gain  <= cfg_data_i[8:0];
        CFG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_data_i[14:0];
        CFG_DECIMATION:   cfg_q.decimation   <= cfg_data_i[2:0];
        CFG_CHAN0_ID:     cfg_q.chan0_id     <= cfg_data_i[10:0];
        CFG_CHAN1_ID:     cfg_q.chan1_id     <= cfg_data_i[10:0];
        default: begin
        end
      endcase
    end
  end

  msp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  msp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item),
    .stat_o       (q_stat)
  );

  msp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_o       (out_o)
  );

  // Unwrapped delta never exceeds half a turn
  a_delta_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.speed_delta >= -14'sd4096 && out_o.speed_delta <= 14'sd4096))
    else $error("speed_delta out of half-turn range");

  // Queue never overfills
  a_queue_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("queue fill count above depth");

  // Queue never pushes into a full slot: a full queue must hold the front stage
  a_queue_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.count == QCNT_W'(QDEPTH)) |-> !push_ready)
    else $error("queue accepts a push while full");

  // No result is presented right out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_o.valid)
    else $error("result valid right after reset");

endmodule

### test/tb_motor_feedback_speed_pid.sv
// Self-checking testbench for motor_feedback_speed_pid: sends feedback frames,
// predicts each status item in a behavioral model of the speed loop and checks it.
// Depends on msp_pkg, msp_in_if, msp_out_if and the block's RTL.
module tb_motor_feedback_speed_pid;
  import msp_pkg::*;

  localparam int IDLE_LIMIT   = 4000;  // cycles with no handshake before giving up
  localparam int SETTLE_WAIT  = 20;    // lets the control update of the last frame finish
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 165;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int REPORT_LIMIT = 10;

  // One received frame as offered on in_i
  typedef struct packed {
    logic [10:0] std_id;
    logic [7:0]  angle_high;
    logic [7:0]  angle_low;
    logic [7:0]  current_high;
    logic [7:0]  current_low;
    logic [7:0]  setcur_high;
    logic [7:0]  setcur_low;
    logic [7:0]  hall_byte;
    logic [15:0] target_speed;
    logic        startup_hold;
  } frame_t;

  // One channel status item as seen on out_o
  typedef struct packed {
    logic        channel;
    logic [12:0] angle;
    logic [13:0] speed_delta;
    logic [15:0] turns;
    logic [31:0] position;
    logic [15:0] current_real;
    logic [15:0] current_set;
    logic [7:0]  hall;
    logic        loop_ran;
    logic [15:0] filtered_speed;
    logic [15:0] drive;
  } status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  msp_in_if  in_if ();
  msp_out_if out_if ();

  motor_feedback_speed_pid DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow registers
  int m_kp, m_ki, m_kd, m_fgain, m_limit, m_decim, m_id0, m_id1;
  // Per-channel loop state
  int      m_last_angle [2];
  bit [15:0] m_turns    [2];
  int      m_position   [2];
  int      m_speed_sum  [2];
  int      m_decim_cnt  [2];
  int      m_filtered   [2];
  longint  m_err1       [2];
  longint  m_err2       [2];
  int      m_out_prev   [2];
  int      m_drive      [2];

  frame_t  frames_to_send [$];
  status_t status_expected [$];
  logic [15:0] cfg_next [8];
  int      gen_angle [2];

  bit offered;        // current frame on in_i not yet taken
  bit last_stretch;   // no idling on either side
  bit rx_hold;        // long receiver hold-off
  int tx_gap, rx_gap;
  int mismatch_cnt;
  int status_seen;
  int idle_cycles;

  function automatic void store_reg(cfg_idx_e idx, logic [15:0] v);
    case (idx)
      CFG_PROP_GAIN:    m_kp    = v;
      CFG_INTEG_GAIN:   m_ki    = v;
      CFG_DERIV_GAIN:   m_kd    = v;
      CFG_FILTER_GAIN:  m_fgain = v[8:0];
      CFG_OUTPUT_LIMIT: m_limit = v[14:0];
      CFG_DECIMATION:   m_decim = v[2:0];
      CFG_CHAN0_ID:     m_id0   = v[10:0];
      CFG_CHAN1_ID:     m_id1   = v[10:0];
      default: ;
    endcase
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Advance one channel by one frame; returns 0 when the id matches no channel
  function automatic bit predict_feedback(input frame_t f, output status_t r);
    int ch, ang, d, spd, cnt;
    longint a, filt, err, acc, o;
    r = '0;
    if (f.std_id == m_id0) ch = 0;
    else if (f.std_id == m_id1) ch = 1;
    else return 1'b0;

    // angle unwrap across the encoder wrap
    ang = {f.angle_high[4:0], f.angle_low};
    d = ang - m_last_angle[ch];
    if (d > ENC_COUNTS / 2) begin
      m_turns[ch] = m_turns[ch] - 16'd1;
      spd = d - ENC_COUNTS;
    end else if (d < -(ENC_COUNTS / 2)) begin
      m_turns[ch] = m_turns[ch] + 16'd1;
      spd = d + ENC_COUNTS;
    end else begin
      spd = d;
    end
    m_last_angle[ch] = ang;
    m_position[ch] = m_position[ch] + spd;
    m_speed_sum[ch] = int'(clamp(longint'(m_speed_sum[ch]) + spd, -32768, 32767));

    cnt = m_decim_cnt[ch] + 1;
    if (cnt >= m_decim) cnt = 0;
    m_decim_cnt[ch] = cnt & 7;

    // filter and incremental PID on the decimated frame
    if (cnt == 0) begin
      a = (m_fgain > 256) ? 256 : m_fgain;
      filt = (a * m_speed_sum[ch] + (256 - a) * m_filtered[ch]) / 256;
      if (f.startup_hold) filt = 0;
      m_filtered[ch] = int'(filt);
      err = longint'($signed(f.target_speed)) - filt;
      acc = (longint'(m_kp) + m_ki + m_kd) * err
            - (longint'(m_kp) + 2 * longint'(m_kd)) * m_err1[ch]
            + longint'(m_kd) * m_err2[ch];
      o = clamp(longint'(m_out_prev[ch]) + acc / 256, -64'sd2147483648, 64'sd2147483647);
      m_err2[ch] = m_err1[ch];
      m_err1[ch] = err;
      m_out_prev[ch] = int'(o);
      m_drive[ch] = int'(clamp(o, -longint'(m_limit), longint'(m_limit)));
      m_speed_sum[ch] = 0;
    end

    r.channel        = ch[0];
    r.angle          = ang[12:0];
    r.speed_delta    = spd[13:0];
    r.turns          = m_turns[ch];
    r.position       = m_position[ch];
    r.current_real   = {f.current_high, f.current_low};
    r.current_set    = {f.setcur_high, f.setcur_low};
    r.hall           = f.hall_byte;
    r.loop_ran       = (cnt == 0);
    r.filtered_speed = m_filtered[ch][15:0];
    r.drive          = m_drive[ch][15:0];
    return 1'b1;
  endfunction

  function automatic frame_t mk_frame(logic [10:0] id, logic [15:0] raw, logic [15:0] cur,
                                      logic [15:0] set, logic [7:0] hall,
                                      logic [15:0] target, logic hold);
    frame_t f;
    f = {id, raw, cur, set, hall, target, hold};
    return f;
  endfunction

  // Mostly a motor turning at a plausible rate, some jumps and stray ids
  function automatic frame_t rand_frame();
    frame_t f;
    int sel, ch, ang;
    ch = 0;
    sel = $urandom_range(0, 19);
    if (sel < 2) begin
      f.std_id = 11'($urandom);
    end else if (sel < 11) begin
      f.std_id = m_id0[10:0];
    end else begin
      f.std_id = m_id1[10:0];
      ch = 1;
    end
    case ($urandom_range(0, 9))
      0: ang = $urandom_range(0, ENC_COUNTS - 1);
      1: ang = gen_angle[ch] + int'($urandom_range(4090, 4102));
      2: ang = gen_angle[ch] - int'($urandom_range(4090, 4102));
      default: ang = gen_angle[ch] + int'($urandom_range(0, 1200)) - 600;
    endcase
    ang = ang & (ENC_COUNTS - 1);
    gen_angle[ch] = ang;
    {f.angle_high, f.angle_low} = {3'($urandom), 13'(ang)};
    {f.current_high, f.current_low} = 16'($urandom);
    {f.setcur_high, f.setcur_low}   = 16'($urandom);
    f.hall_byte = 8'($urandom);
    if ($urandom_range(0, 3) == 0) f.target_speed = 16'($urandom);
    else f.target_speed = 16'(int'($urandom_range(0, 4000)) - 2000);
    f.startup_hold = ($urandom_range(0, 15) == 0);
    return f;
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 600));
    endcase
  endfunction

  function automatic string fmt_status(status_t r);
    return $sformatf("ch=%0d ang=%0d dlt=%0d trn=%0d pos=%0d cur=%0d set=%0d hall=%0d run=%0d filt=%0d drv=%0d",
                     r.channel, r.angle, $signed(r.speed_delta), $signed(r.turns),
                     $signed(r.position), $signed(r.current_real), $signed(r.current_set),
                     r.hall, r.loop_ran, $signed(r.filtered_speed), $signed(r.drive));
  endfunction

  // Let the block drain, then write all registers from cfg_next
  task automatic write_config();
    while (frames_to_send.size() != 0 || status_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= cfg_next[i];
      store_reg(cfg_idx_e'(i), cfg_next[i]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Frame driver: predict on acceptance
  always @(posedge clk_i) begin : take_frame
    status_t st;
    if (rst_ni && in_if.valid && in_if.ready) begin
      if (predict_feedback(frames_to_send[0], st)) status_expected.push_back(st);
      void'(frames_to_send.pop_front());
      offered = 1'b0;
    end
  end

  // Frame driver: offer at the falling edge
  always @(negedge clk_i) begin
    if (!offered) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_if.valid <= 1'b0;
      end else if (frames_to_send.size() != 0) begin
        if (!last_stretch && $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(1, 10) - 1;
          in_if.valid <= 1'b0;
        end else begin
          in_if.std_id       <= frames_to_send[0].std_id;
          in_if.angle_high   <= frames_to_send[0].angle_high;
          in_if.angle_low    <= frames_to_send[0].angle_low;
          in_if.current_high <= frames_to_send[0].current_high;
          in_if.current_low  <= frames_to_send[0].current_low;
          in_if.setcur_high  <= frames_to_send[0].setcur_high;
          in_if.setcur_low   <= frames_to_send[0].setcur_low;
          in_if.hall_byte    <= frames_to_send[0].hall_byte;
          in_if.target_speed <= frames_to_send[0].target_speed;
          in_if.startup_hold <= frames_to_send[0].startup_hold;
          in_if.valid        <= 1'b1;
          offered = 1'b1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk_i) begin
    if (rx_hold) begin
      out_if.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_if.ready <= 1'b0;
    end else if (!last_stretch && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(1, 10) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Status monitor
  always @(posedge clk_i) begin : check_status
    status_t got, want;
    string bad;
    if (rst_ni && out_if.valid && out_if.ready) begin
      status_seen++;
      got = {out_if.channel, out_if.angle, out_if.speed_delta, out_if.turns, out_if.position,
             out_if.current_real, out_if.current_set, out_if.hall, out_if.loop_ran,
             out_if.filtered_speed, out_if.drive};
      if (status_expected.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT)
          $display("unexpected status item: %s", fmt_status(got));
      end else begin
        want = status_expected.pop_front();
        bad = "";
        if (got.channel        !== want.channel)        bad = {bad, " channel"};
        if (got.angle          !== want.angle)          bad = {bad, " angle"};
        if (got.speed_delta    !== want.speed_delta)    bad = {bad, " speed_delta"};
        if (got.turns          !== want.turns)          bad = {bad, " turns"};
        if (got.position       !== want.position)       bad = {bad, " position"};
        if (got.current_real   !== want.current_real)   bad = {bad, " current_real"};
        if (got.current_set    !== want.current_set)    bad = {bad, " current_set"};
        if (got.hall           !== want.hall)           bad = {bad, " hall"};
        if (got.loop_ran       !== want.loop_ran)       bad = {bad, " loop_ran"};
        if (got.filtered_speed !== want.filtered_speed) bad = {bad, " filtered_speed"};
        if (got.drive          !== want.drive)          bad = {bad, " drive"};
        if (bad != "") begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT) begin
            $display("status mismatch in%s", bad);
            $display("  expected %s", fmt_status(want));
            $display("  actual   %s", fmt_status(got));
          end
        end
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_motor_feedback_speed_pid NOT OK");
        $finish;
      end
    end
  end

  // Long hold-off while frames keep coming, so the queue fills and in_i stalls
  initial begin
    rx_hold = 1'b0;
    while (!(status_seen >= 400 && frames_to_send.size() > 60)) @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // Stimulus
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_PROP_GAIN;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    {in_if.std_id, in_if.angle_high, in_if.angle_low, in_if.current_high,
     in_if.current_low, in_if.setcur_high, in_if.setcur_low, in_if.hall_byte,
     in_if.target_speed, in_if.startup_hold} = '0;
    out_if.ready = 1'b0;
    offered = 1'b0;
    last_stretch = 1'b0;
    tx_gap = 0;
    rx_gap = 0;
    mismatch_cnt = 0;
    status_seen = 0;
    idle_cycles = 0;
    gen_angle[0] = 0;
    gen_angle[1] = 0;

    // model reset state
    m_kp = 0; m_ki = 0; m_kd = 0;
    m_fgain = FILTER_GAIN_RST; m_limit = OUTPUT_LIMIT_RST; m_decim = DECIMATION_RST;
    m_id0 = CHAN0_ID_RST; m_id1 = CHAN1_ID_RST;
    for (int c = 0; c < 2; c++) begin
      m_last_angle[c] = 0; m_turns[c] = '0; m_position[c] = 0; m_speed_sum[c] = 0;
      m_decim_cnt[c] = 1; m_filtered[c] = 0; m_err1[c] = 0; m_err2[c] = 0;
      m_out_prev[c] = 0; m_drive[c] = 0;
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: cfg_next = '{16'h0200, 16'h0040, 16'h0020, 16'd102, 16'd5000, 16'd1,
                        16'h201, 16'h203};
        // all gains at maximum, slowest decimation
        1: cfg_next = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd256, 16'h7FFF, 16'd7,
                        16'h7FF, 16'h000};
        // zero gains and limit, decimation zero, both ids equal
        2: cfg_next = '{16'h0000, 16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0,
                        16'h123, 16'h123};
        // filter weight above unity, tiny limit
        3: cfg_next = '{rand_gain(), rand_gain(), rand_gain(), 16'h01FF, 16'd1, 16'd2,
                        16'h555, 16'h2AA};
        default: begin
          cfg_next[CFG_PROP_GAIN]    = rand_gain();
          cfg_next[CFG_INTEG_GAIN]   = rand_gain();
          cfg_next[CFG_DERIV_GAIN]   = rand_gain();
          cfg_next[CFG_FILTER_GAIN]  = ($urandom_range(0, 9) == 0) ?
                                       16'($urandom_range(257, 511)) :
                                       16'($urandom_range(0, 256));
          cfg_next[CFG_OUTPUT_LIMIT] = 16'($urandom_range(0, 32767));
          cfg_next[CFG_DECIMATION]   = 16'($urandom_range(0, 7));
          cfg_next[CFG_CHAN0_ID]     = 16'($urandom_range(0, 2047));
          cfg_next[CFG_CHAN1_ID]     = ($urandom_range(0, 5) == 0) ?
                                       cfg_next[CFG_CHAN0_ID] :
                                       16'($urandom_range(0, 2047));
        end
      endcase
      write_config();
      if (p == PHASES - 1) last_stretch = 1'b1;

      if (p == 0) begin
        // angle edges: half-turn boundaries, wrap both ways, dropped high bits
        frames_to_send.push_back(mk_frame(11'h201, 16'h0000, 16'h0000, 16'hFFFF, 8'h00,
                                          16'h0000, 1'b0));
        frames_to_send.push_back(mk_frame(11'h201, 16'h1000, 16'h0001, 16'h8000, 8'h01,
                                          16'h0064, 1'b0));
        frames_to_send.push_back(mk_frame(11'h201, 16'h2000, 16'h7FFF, 16'h0000, 8'h80,
                                          16'hFF9C, 1'b0));
        frames_to_send.push_back(mk_frame(11'h201, 16'h1FFF, 16'h8000, 16'h7FFF, 8'hFF,
                                          16'h0000, 1'b0));
        frames_to_send.push_back(mk_frame(11'h201, 16'hE001, 16'hFFFF, 16'h0001, 8'hA5,
                                          16'h03E8, 1'b0));
        frames_to_send.push_back(mk_frame(11'h201, 16'hFFFF, 16'h5A5A, 16'hA5A5, 8'h5A,
                                          16'h03E8, 1'b0));
        frames_to_send.push_back(mk_frame(11'h203, 16'h1001, 16'h1234, 16'hFEDC, 8'h3C,
                                          16'h0000, 1'b0));
        frames_to_send.push_back(mk_frame(11'h203, 16'h0000, 16'h0F0F, 16'hF0F0, 8'hC3,
                                          16'h0000, 1'b0));
        // target extremes and startup hold
        frames_to_send.push_back(mk_frame(11'h203, 16'h0100, 16'h0000, 16'h0000, 8'h00,
                                          16'h7FFF, 1'b0));
        frames_to_send.push_back(mk_frame(11'h203, 16'h0200, 16'h0000, 16'h0000, 8'h00,
                                          16'h8000, 1'b0));
        frames_to_send.push_back(mk_frame(11'h201, 16'h0040, 16'h0000, 16'h0000, 8'h00,
                                          16'h0064, 1'b1));
        frames_to_send.push_back(mk_frame(11'h203, 16'h0300, 16'h0000, 16'h0000, 8'h00,
                                          16'h8000, 1'b1));
        // ids that match neither channel, then one more channel 0 frame
        frames_to_send.push_back(mk_frame(11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                                          16'hFFFF, 1'b1));
        frames_to_send.push_back(mk_frame(11'h000, 16'h0000, 16'h0000, 16'h0000, 8'h00,
                                          16'h0000, 1'b0));
        frames_to_send.push_back(mk_frame(11'h202, 16'h1234, 16'h0000, 16'h0000, 8'h00,
                                          16'h0000, 1'b0));
        frames_to_send.push_back(mk_frame(11'h201, 16'h0001, 16'hFFFF, 16'hFFFF, 8'hFF,
                                          16'h7FFF, 1'b0));
        gen_angle[0] = 1;
        gen_angle[1] = 16'h0300;
      end
      repeat (PHASE_ITEMS) frames_to_send.push_back(rand_frame());
    end

    while (frames_to_send.size() != 0 || status_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_motor_feedback_speed_pid OK");
    end else begin
      $display("tb_motor_feedback_speed_pid NOT OK");
    end
    $finish;
  end

endmodule
